/* hdl/fit_policy_partition_allocator_top_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef FIT_POLICY_PARTITION_ALLOCATOR_TOP_MACROS_SVH
`define FIT_POLICY_PARTITION_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock outside reset.
`define FPPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock outside reset.
`define FPPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/fppa_pkg.sv */
// Shared types, codes and defaults of the fit-policy partition allocator.
package fppa_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 32;
   localparam int SIZE_WIDTH_DEFAULT = 16;

   localparam int INDEX_FIELD_WIDTH = 5;
   localparam int SIZE_FIELD_WIDTH  = 16;
   localparam int MODE_WIDTH        = 2;
   localparam int COUNT_WIDTH       = 6;
   localparam int CSR_INDEX_WIDTH   = 4;
   localparam int CSR_DATA_WIDTH    = 8;

   // fit modes; the unused code behaves as first fit
   localparam logic [MODE_WIDTH-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_WORST = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIT_MODE    = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_COUNT = 4'd1;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]  fit_mode;
      logic [COUNT_WIDTH-1:0] block_count;
   } cfg_type;

   typedef struct packed {
      logic                         req_type;
      logic [INDEX_FIELD_WIDTH-1:0] block_index;
      logic [SIZE_FIELD_WIDTH-1:0]  size;
   } req_item_type;

   typedef struct packed {
      logic                         granted;
      logic [INDEX_FIELD_WIDTH-1:0] block_number;
      logic [SIZE_FIELD_WIDTH-1:0]  remaining;
   } rsp_item_type;

endpackage

/* hdl/fppa_engine.sv */
// Partition table memory and the sequential scan that picks a partition.
`include "fit_policy_partition_allocator_top_macros.svh"

module fppa_engine #(
   parameter int MAX_BLOCKS = fppa_pkg::MAX_BLOCKS_DEFAULT,
   parameter int SIZE_WIDTH = fppa_pkg::SIZE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fppa_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  fppa_pkg::req_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output fppa_pkg::rsp_item_type out_item
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [SIZE_WIDTH-1:0] free_sizes_ff [MAX_BLOCKS];
   logic [SIZE_WIDTH-1:0] rd_data_ff;

   logic [1:0]            state_ff, state_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         limit_ff, limit_in;
   logic [SIZE_WIDTH-1:0] size_ff, size_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         pick_ff, pick_in;
   logic [SIZE_WIDTH-1:0] pick_size_ff, pick_size_in;

   logic                  accept;
   logic                  load_ok;
   logic                  is_best, is_worst, is_first;
   logic                  fits, last;
   logic [CW-1:0]         limit_now;
   logic [IW-1:0]         rd_addr;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [SIZE_WIDTH-1:0] wr_data;
   logic [SIZE_WIDTH-1:0] left;

   assign in_ready = (state_ff == ST_IDLE);
   assign accept   = in_valid && in_ready;
   assign load_ok  = int'(in_item.block_index) < MAX_BLOCKS;

   assign is_best  = (cfg.fit_mode == fppa_pkg::MODE_BEST);
   assign is_worst = (cfg.fit_mode == fppa_pkg::MODE_WORST);
   assign is_first = !is_best && !is_worst;

   assign limit_now = (int'(cfg.block_count) > MAX_BLOCKS) ? CW'(MAX_BLOCKS)
                                                           : CW'(cfg.block_count);

   assign fits = (rd_data_ff >= size_ff);
   assign last = (CW'({1'b0, cnt_ff}) + CW'(1)) == limit_ff;
   assign left = pick_size_ff - size_ff;

   // read one entry ahead of the one being judged
   assign rd_addr = (state_ff == ST_SCAN) ? IW'({1'b0, cnt_ff} + (IW+1)'(1)) : '0;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pick_ff;
      wr_data = left;
      if (accept && in_item.req_type == fppa_pkg::REQ_LOAD && load_ok) begin
         wr_en   = 1'b1;
         wr_addr = IW'(in_item.block_index);
         wr_data = SIZE_WIDTH'(in_item.size);
      end else if (state_ff == ST_DONE && out_ready && found_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_sizes_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= free_sizes_ff[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      size_in      = size_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_size_in = pick_size_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && in_item.req_type == fppa_pkg::REQ_ALLOC) begin
               size_in  = SIZE_WIDTH'(in_item.size);
               limit_in = limit_now;
               cnt_in   = '0;
               found_in = 1'b0;
               pick_in  = '0;
               state_in = (limit_now == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (fits && !found_ff) begin
               found_in     = 1'b1;
               pick_in      = cnt_ff;
               pick_size_in = rd_data_ff;
            end else if (fits && is_best && rd_data_ff < pick_size_ff) begin
               pick_in      = cnt_ff;
               pick_size_in = rd_data_ff;
            end else if (fits && is_worst && rd_data_ff > pick_size_ff) begin
               pick_in      = cnt_ff;
               pick_size_in = rd_data_ff;
            end
            if (last || (fits && !found_ff && is_first)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = IW'({1'b0, cnt_ff} + (IW+1)'(1));
            end
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
      cnt_ff       <= cnt_in;
      limit_ff     <= limit_in;
      size_ff      <= size_in;
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
   end

   assign out_valid             = (state_ff == ST_DONE);
   assign out_item.granted      = found_ff;
   assign out_item.block_number = found_ff ? fppa_pkg::INDEX_FIELD_WIDTH'(pick_ff) : '0;
   assign out_item.remaining    = found_ff ? fppa_pkg::SIZE_FIELD_WIDTH'(left) : '0;

   `FPPA_ASSERT_NOW(a_scan_in_range, state_ff == ST_SCAN,
      CW'({1'b0, cnt_ff}) < limit_ff, "scan index beyond partition count")
   `FPPA_ASSERT_NOW(a_pick_fits, state_ff == ST_SCAN && found_ff,
      pick_size_ff >= size_ff, "chosen partition smaller than request")
   `FPPA_ASSERT_NOW(a_pick_in_range, state_ff == ST_DONE && found_ff,
      CW'({1'b0, pick_ff}) < limit_ff, "chosen partition outside scanned range")
   `FPPA_ASSERT_NEXT(a_done_retires, state_ff == ST_DONE && out_ready,
      state_ff == ST_IDLE, "handed-over result did not retire the item")

endmodule

/* hdl/fit_policy_partition_allocator_top.sv */
// Top level of the fit-policy partition allocator: ports, registers, result stage.
//
// The block holds a table of free sizes for up to MAX_BLOCKS partitions in a
// synchronous RAM. A load item (req_tuser 0) writes one partition's size and
// yields no result. An allocate item (req_tuser 1) scans partitions
// 0 .. min(block_count, MAX_BLOCKS)-1 through the RAM's single read port,
// one entry per cycle, picks one by fit_mode (first, best or worst fit, ties
// to the lower index), subtracts the request and writes it back. First fit
// stops at its first hit; a zero block_count gives a not-granted result
// with no scan. A finished result sits in the output register so the next
// item can be taken while it waits. Load every partition in use before
// allocating; a partition never loaded reads back as an arbitrary size.
// Write the CSRs only while no item is in flight.
`include "fit_policy_partition_allocator_top_macros.svh"

module fit_policy_partition_allocator_top #(
   parameter int MAX_BLOCKS = fppa_pkg::MAX_BLOCKS_DEFAULT,
   parameter int SIZE_WIDTH = fppa_pkg::SIZE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [23:0]                          req_tdata,  // block_index, size, zero pad
   input  logic                                 req_tuser,  // req_type
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [23:0]                          rsp_tdata,  // block_number, remaining, zero pad
   output logic                                 rsp_tuser,  // granted
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fppa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fppa_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   fppa_pkg::cfg_type      cfg_ff;
   fppa_pkg::req_item_type req_item;
   fppa_pkg::rsp_item_type eng_item;
   fppa_pkg::rsp_item_type rsp_item_ff;
   logic                   rsp_valid_ff;
   logic                   eng_valid;
   logic                   eng_ready;

   // Registers are always writable; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fit_mode    <= fppa_pkg::MODE_FIRST;
         cfg_ff.block_count <= fppa_pkg::COUNT_WIDTH'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fppa_pkg::CSR_FIT_MODE: begin
               cfg_ff.fit_mode <= csr_data[fppa_pkg::MODE_WIDTH-1:0];
            end
            fppa_pkg::CSR_BLOCK_COUNT: begin
               cfg_ff.block_count <= csr_data[fppa_pkg::COUNT_WIDTH-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Unpack the request item.
   assign req_item.req_type    = req_tuser;
   assign req_item.block_index = req_tdata[4:0];
   assign req_item.size        = req_tdata[20:5];

   fppa_engine #(
      .MAX_BLOCKS(MAX_BLOCKS),
      .SIZE_WIDTH(SIZE_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (req_item),
      .out_valid(eng_valid),
      .out_ready(eng_ready),
      .out_item (eng_item)
   );

   // Output register: take a new result when empty or being drained.
   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_ready) begin
         rsp_valid_ff <= eng_valid;
      end
      if (eng_ready && eng_valid) begin
         rsp_item_ff <= eng_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.granted;
   assign rsp_tdata  = {3'b000, rsp_item_ff.remaining, rsp_item_ff.block_number};

endmodule

/* bench/tb_top.sv */
// Self-checking testbench of the fit-policy partition allocator.
`timescale 1ns / 100ps

module tb_top;

   // the fourth mode code is not a policy of its own and must act as first fit
   localparam logic [fppa_pkg::MODE_WIDTH-1:0] MODE_SPARE = 2'd3;
   localparam int NUM_PARTS    = fppa_pkg::MAX_BLOCKS_DEFAULT;
   localparam int IDLE_PERCENT = 21;
   localparam int SETTLE_CYCLES = 40;   // long enough for a trailing allocate scan to finish
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int NUM_PHASES   = 12;
   localparam int PHASE_ITEMS  = 105;

   // Keeps its own copy of the free-size table and the two registers, predicts
   // the grant of each allocate and checks results against them in order.
   class partition_ledger;
      logic [fppa_pkg::SIZE_FIELD_WIDTH-1:0] free_size [NUM_PARTS];
      logic [fppa_pkg::MODE_WIDTH-1:0]       mode  = fppa_pkg::MODE_FIRST;
      logic [fppa_pkg::COUNT_WIDTH-1:0]      count = 6'd1;
      fppa_pkg::rsp_item_type                pending_grants [$];
      int                                    errors = 0;

      task report(string what, longint got, longint want);
         errors++;
         if (errors <= 100)
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      endtask

      // Apply one accepted item; an allocate leaves one expected result.
      task note_item(fppa_pkg::req_item_type it);
         int                     span;
         int                     pick;
         bit                     hit;
         fppa_pkg::rsp_item_type grant;
         if (it.req_type == fppa_pkg::REQ_LOAD) begin
            free_size[it.block_index] = it.size;
            return;
         end
         span  = (count > NUM_PARTS) ? NUM_PARTS : int'(count);
         hit   = 1'b0;
         pick  = 0;
         grant = '0;
         for (int k = 0; k < span; k++) begin
            if (free_size[k] < it.size)
               continue;
            if (!hit) begin
               hit  = 1'b1;
               pick = k;
               if (mode != fppa_pkg::MODE_BEST && mode != fppa_pkg::MODE_WORST)
                  break;
            end else if (mode == fppa_pkg::MODE_BEST && free_size[k] < free_size[pick]) begin
               pick = k;
            end else if (mode == fppa_pkg::MODE_WORST && free_size[k] > free_size[pick]) begin
               pick = k;
            end
         end
         if (hit) begin
            free_size[pick]    = free_size[pick] - it.size;
            grant.granted      = 1'b1;
            grant.block_number = 5'(pick);
            grant.remaining    = free_size[pick];
         end
         pending_grants.push_back(grant);
      endtask

      task check_result(fppa_pkg::rsp_item_type got);
         fppa_pkg::rsp_item_type want;
         if (pending_grants.size() == 0) begin
            report("result with nothing pending, granted", got.granted, 0);
            return;
         end
         want = pending_grants.pop_front();
         if (got.granted !== want.granted)
            report("granted", got.granted, want.granted);
         if (got.block_number !== want.block_number)
            report("block_number", got.block_number, want.block_number);
         if (got.remaining !== want.remaining)
            report("remaining", got.remaining, want.remaining);
      endtask
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [23:0]                          req_tdata = '0;   // block_index, size, zero pad
   logic                                 req_tuser = 1'b0; // req_type
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [23:0]                          rsp_tdata;        // block_number, remaining, zero pad
   logic                                 rsp_tuser;        // granted
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [fppa_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [fppa_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   partition_ledger ledger = new();
   bit              no_idle = 1'b0;   // set for one long stretch of back-to-back traffic
   int              cycles = 0;

   fit_policy_partition_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Stall the result side at random, except during the no-idle stretch.
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Check every accepted result against the oldest pending grant.
   always @(posedge clock) begin
      fppa_pkg::rsp_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.granted      = rsp_tuser;
         got.block_number = rsp_tdata[4:0];
         got.remaining    = rsp_tdata[20:5];
         ledger.check_result(got);
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one item, idling first at random; leave tvalid high on return so
   // that a following item needs no second assignment in the same step.
   task automatic send_item(logic kind, logic [fppa_pkg::INDEX_FIELD_WIDTH-1:0] idx,
                            logic [fppa_pkg::SIZE_FIELD_WIDTH-1:0] sz);
      fppa_pkg::req_item_type it;
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, sz, idx};
      do @(posedge clock); while (!req_tready);
      it.req_type    = kind;
      it.block_index = idx;
      it.size        = sz;
      ledger.note_item(it);
   endtask

   // Hold the sender until every pending grant has arrived, then let a
   // trailing load or scan finish before anything touches the registers.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (ledger.pending_grants.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back; call only with the block idle.
   task automatic set_regs(logic [fppa_pkg::MODE_WIDTH-1:0] mode,
                           logic [fppa_pkg::COUNT_WIDTH-1:0] count);
      csr_valid <= 1'b1;
      csr_index <= fppa_pkg::CSR_FIT_MODE;
      csr_data  <= fppa_pkg::CSR_DATA_WIDTH'(mode);
      do @(posedge clock); while (!csr_ready);
      csr_index <= fppa_pkg::CSR_BLOCK_COUNT;
      csr_data  <= fppa_pkg::CSR_DATA_WIDTH'(count);
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      ledger.mode  = mode;
      ledger.count = count;
   endtask

   // Mostly allocates with sizes that often fit, the rest reloads.
   task automatic random_item();
      int unsigned                           roll;
      logic [fppa_pkg::SIZE_FIELD_WIDTH-1:0] sz;
      roll = $urandom_range(99);
      if (roll < 25) begin
         roll = $urandom_range(99);
         if (roll < 10)      sz = '0;
         else if (roll < 20) sz = '1;
         else if (roll < 60) sz = 16'($urandom_range(0, 4000));
         else                sz = 16'($urandom);
         send_item(fppa_pkg::REQ_LOAD, 5'($urandom_range(0, NUM_PARTS - 1)), sz);
      end else begin
         roll = $urandom_range(99);
         if (roll < 5)       sz = '0;
         else if (roll < 10) sz = '1;
         else if (roll < 50) sz = 16'($urandom_range(0, 300));
         else if (roll < 80) sz = 16'($urandom_range(0, 5000));
         else                sz = 16'($urandom);
         send_item(fppa_pkg::REQ_ALLOC, 5'($urandom), sz);
      end
   endtask

   initial begin
      logic [fppa_pkg::COUNT_WIDTH-1:0] count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: four partitions at the size extremes, then every mode.
      set_regs(fppa_pkg::MODE_FIRST, 6'd4);
      send_item(fppa_pkg::REQ_LOAD, 5'd0, 16'hFFFF);
      send_item(fppa_pkg::REQ_LOAD, 5'd1, 16'h0000);
      send_item(fppa_pkg::REQ_LOAD, 5'd2, 16'd100);
      send_item(fppa_pkg::REQ_LOAD, 5'd3, 16'd50);
      send_item(fppa_pkg::REQ_LOAD, 5'd31, 16'h1234);   // top index, outside the scan for now
      send_item(fppa_pkg::REQ_ALLOC, 5'd0, 16'h0000);   // zero-size request fits the first one
      send_item(fppa_pkg::REQ_ALLOC, 5'd31, 16'hFFFF);  // drains the full partition to zero
      send_item(fppa_pkg::REQ_ALLOC, 5'd0, 16'hFFFF);   // nothing fits: not granted
      send_item(fppa_pkg::REQ_ALLOC, 5'd0, 16'd60);
      settle();
      set_regs(fppa_pkg::MODE_BEST, 6'd4);
      send_item(fppa_pkg::REQ_ALLOC, 5'd0, 16'd30);
      send_item(fppa_pkg::REQ_ALLOC, 5'd0, 16'd0);      // tie between two empty partitions
      settle();
      set_regs(fppa_pkg::MODE_WORST, 6'd4);
      send_item(fppa_pkg::REQ_ALLOC, 5'd0, 16'd5);
      send_item(fppa_pkg::REQ_LOAD, 5'd2, 16'd45);
      send_item(fppa_pkg::REQ_ALLOC, 5'd0, 16'd0);      // tie between two largest partitions
      settle();
      set_regs(MODE_SPARE, 6'd4);
      send_item(fppa_pkg::REQ_ALLOC, 5'd0, 16'd1);
      settle();
      set_regs(fppa_pkg::MODE_FIRST, 6'd0);
      send_item(fppa_pkg::REQ_ALLOC, 5'd0, 16'd0);      // empty scan: never granted

      // Load the whole table so that no scan reads an unwritten entry.
      for (int i = 0; i < NUM_PARTS; i++)
         send_item(fppa_pkg::REQ_LOAD, 5'(i), 16'($urandom));

      // Random phases, each under its own register setting.
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         case (p)
            0:       count = 6'd32;
            1:       count = 6'd1;
            2:       count = 6'd0;
            3:       count = 6'd63;   // saturates to the table size
            4:       count = 6'd33;
            5:       count = 6'd32;
            default: count = 6'($urandom_range(0, 63));
         endcase
         set_regs(fppa_pkg::MODE_WIDTH'(p % 4), count);
         no_idle = (p == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // pause mid-phase until the pipe is empty, with no register change
            if (p == 7 && n == PHASE_ITEMS / 2)
               settle();
            random_item();
         end
      end
      no_idle = 1'b0;

      settle();
      if (ledger.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
